>>> hw/rtl/oaht_pkg.sv
package oaht_pkg;

  localparam int unsigned Capacity   = 1024;
  localparam int unsigned IdxW       = $clog2(Capacity);
  localparam int unsigned CntW       = IdxW + 1;
  localparam int unsigned KeyW       = 32;
  localparam int unsigned ValW       = 32;
  localparam int unsigned OpW        = 3;
  localparam int unsigned LimW       = CntW + 3;
  localparam logic [LimW-1:0] LoadLimit = LimW'(2 * Capacity);

  typedef enum logic [1:0] {
    MarkEmpty    = 2'd0,
    MarkOccupied = 2'd1,
    MarkDeleted  = 2'd2
  } mark_e;

  typedef enum logic [OpW-1:0] {
    OpLookup  = 3'd0,
    OpAdd     = 3'd1,
    OpRemove  = 3'd2,
    OpClear   = 3'd3,
    OpIterate = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    StInit,
    StIdle,
    StProbeRd,
    StProbeChk,
    StWrite,
    StIterRd,
    StIterChk,
    StClear,
    StDone
  } state_e;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    logic [1:0]      wmark;
    logic            wkv;
    logic            wval;
  } mem_ctrl_t;

endpackage

>>> hw/rtl/oaht_store.sv
module oaht_store (
  input  logic                            clk_i,
  input  oaht_pkg::mem_ctrl_t             ctrl_i,
  input  logic [oaht_pkg::KeyW-1:0]       wkey_i,
  input  logic [oaht_pkg::ValW-1:0]       wval_i,
  input  logic [oaht_pkg::IdxW-1:0]       raddr_i,
  output logic [1:0]                      rmark_o,
  output logic [oaht_pkg::KeyW-1:0]       rkey_o,
  output logic [oaht_pkg::ValW-1:0]       rval_o
);

  logic [1:0]                mark_mem [oaht_pkg::Capacity];
  logic [oaht_pkg::KeyW-1:0] key_mem  [oaht_pkg::Capacity];
  logic [oaht_pkg::ValW-1:0] val_mem  [oaht_pkg::Capacity];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) begin
      mark_mem[ctrl_i.waddr] <= ctrl_i.wmark;
    end
    rmark_o <= mark_mem[raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.we && ctrl_i.wkv) begin
      key_mem[ctrl_i.waddr] <= wkey_i;
    end
    rkey_o <= key_mem[raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.we && ctrl_i.wval) begin
      val_mem[ctrl_i.waddr] <= wval_i;
    end
    rval_o <= val_mem[raddr_i];
  end

endmodule

>>> hw/rtl/open_address_hash_table.sv
// Lookup/add/remove walk a probe sequence of slots; iterate scans slots from
// start_index_i; clear sweeps every slot (one slot per cycle).
// Throughput: one transaction at a time; the single read port of the mark/key/value
// store is walked by the probe sequencer. Result held in an output register until taken.
// Reset: asynchronous, active low; then a sweep marks all slots
// empty with in_ready_o low.
module open_address_hash_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [oaht_pkg::OpW-1:0]       opcode_i,
  input  logic [31:0]                    key_i,
  input  logic [31:0]                    hash_value_i,
  input  logic [31:0]                    value_i,
  input  logic [31:0]                    default_value_i,
  input  logic [10:0]                    start_index_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           found_o,
  output logic                           status_o,
  output logic [31:0]                    result_value_o,
  output logic [31:0]                    result_key_o,
  output logic [10:0]                    slot_index_o,
  output logic [10:0]                    entry_count_o
);

  localparam int unsigned IdxW = oaht_pkg::IdxW;
  localparam int unsigned CntW = oaht_pkg::CntW;

  oaht_pkg::state_e state_q, state_d;
  logic [oaht_pkg::OpW-1:0]  op_q, op_d;
  logic [31:0]     key_q, key_d, val_q, val_d, defv_q, defv_d;
  logic [IdxW-1:0] idx_q, idx_d, tomb_q, tomb_d;
  logic [CntW-1:0] step_q, step_d;
  logic            have_tomb_q, have_tomb_d;
  logic [CntW-1:0] occ_q, occ_d, tmb_q, tmb_d;
  logic            hit_q, hit_d;
  logic            found_q, found_d, status_q, status_d;
  logic [31:0]     rval_q, rval_d, rkey_q, rkey_d;
  logic [10:0]     sidx_q, sidx_d;

  oaht_pkg::mem_ctrl_t mctl;
  logic [IdxW-1:0] raddr;
  logic [1:0]      rmark;
  logic [31:0]     rkey, rval;
  logic [oaht_pkg::LimW-1:0] load;

  oaht_store u_store (
    .clk_i   (clk_i),
    .ctrl_i  (mctl),
    .wkey_i  (key_q),
    .wval_i  (val_q),
    .raddr_i (raddr),
    .rmark_o (rmark),
    .rkey_o  (rkey),
    .rval_o  (rval)
  );

  assign load = oaht_pkg::LimW'(occ_q + tmb_q + CntW'(1)) * oaht_pkg::LimW'(3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= oaht_pkg::StInit;
      occ_q       <= '0;
      tmb_q       <= '0;
      idx_q       <= '0;
      step_q      <= '0;
      have_tomb_q <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      tmb_q       <= tmb_d;
      idx_q       <= idx_d;
      step_q      <= step_d;
      have_tomb_q <= have_tomb_d;
      hit_q       <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    val_q    <= val_d;
    defv_q   <= defv_d;
    tomb_q   <= tomb_d;
    found_q  <= found_d;
    status_q <= status_d;
    rval_q   <= rval_d;
    rkey_q   <= rkey_d;
    sidx_q   <= sidx_d;
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    val_d       = val_q;
    defv_d      = defv_q;
    idx_d       = idx_q;
    tomb_d      = tomb_q;
    step_d      = step_q;
    have_tomb_d = have_tomb_q;
    occ_d       = occ_q;
    tmb_d       = tmb_q;
    hit_d       = hit_q;
    found_d     = found_q;
    status_d    = status_q;
    rval_d      = rval_q;
    rkey_d      = rkey_q;
    sidx_d      = sidx_q;
    raddr       = idx_q;
    mctl        = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;

    case (state_q)
      oaht_pkg::StInit, oaht_pkg::StClear: begin
        mctl.we    = 1'b1;
        mctl.waddr = idx_q;
        mctl.wmark = oaht_pkg::MarkEmpty;
        idx_d      = idx_q + IdxW'(1);
        if (idx_q == IdxW'(oaht_pkg::Capacity - 1)) begin
          state_d = (state_q == oaht_pkg::StInit) ? oaht_pkg::StIdle : oaht_pkg::StDone;
        end
      end
      oaht_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d        = opcode_i;
          key_d       = key_i;
          val_d       = value_i;
          defv_d      = default_value_i;
          idx_d       = hash_value_i[IdxW-1:0];
          step_d      = CntW'(1);
          have_tomb_d = 1'b0;
          hit_d       = 1'b0;
          found_d     = 1'b0;
          status_d    = 1'b0;
          rval_d      = '0;
          rkey_d      = '0;
          sidx_d      = '0;
          case (opcode_i)
            oaht_pkg::OpLookup, oaht_pkg::OpRemove: state_d = oaht_pkg::StProbeRd;
            oaht_pkg::OpAdd: begin
              if (load >= oaht_pkg::LoadLimit) begin
                status_d = 1'b1;
                state_d  = oaht_pkg::StDone;
              end else begin
                state_d = oaht_pkg::StProbeRd;
              end
            end
            oaht_pkg::OpClear: begin
              idx_d   = '0;
              occ_d   = '0;
              tmb_d   = '0;
              state_d = oaht_pkg::StClear;
            end
            oaht_pkg::OpIterate: begin
              sidx_d = 11'(oaht_pkg::Capacity);
              if (occ_q != '0 && start_index_i < 11'(oaht_pkg::Capacity)) begin
                idx_d   = start_index_i[IdxW-1:0];
                state_d = oaht_pkg::StIterRd;
              end else begin
                state_d = oaht_pkg::StDone;
              end
            end
            default: state_d = oaht_pkg::StDone;
          endcase
        end
      end
      oaht_pkg::StProbeRd: state_d = oaht_pkg::StProbeChk;
      oaht_pkg::StProbeChk: begin
        if (rmark == oaht_pkg::MarkEmpty) begin
          if (have_tomb_q) idx_d = tomb_q;
          state_d = oaht_pkg::StWrite;
        end else if (rmark == oaht_pkg::MarkOccupied && rkey == key_q) begin
          hit_d   = 1'b1;
          state_d = oaht_pkg::StWrite;
        end else begin
          if (rmark == oaht_pkg::MarkDeleted && !have_tomb_q) begin
            have_tomb_d = 1'b1;
            tomb_d      = idx_q;
          end
          if (step_q == CntW'(oaht_pkg::Capacity)) begin
            if (have_tomb_q || rmark == oaht_pkg::MarkDeleted) begin
              idx_d = have_tomb_q ? tomb_q : idx_q;
            end
            state_d = oaht_pkg::StWrite;
          end else begin
            idx_d   = idx_q + step_q[IdxW-1:0];
            step_d  = step_q + CntW'(1);
            state_d = oaht_pkg::StProbeRd;
          end
        end
      end
      oaht_pkg::StWrite: begin
        sidx_d  = 11'(idx_q);
        found_d = hit_q;
        state_d = oaht_pkg::StDone;
        case (op_q)
          oaht_pkg::OpLookup: rval_d = hit_q ? rval : defv_q;
          oaht_pkg::OpAdd: begin
            mctl.we    = 1'b1;
            mctl.waddr = idx_q;
            mctl.wval  = 1'b1;
            if (hit_q) begin
              mctl.wmark = oaht_pkg::MarkOccupied;
            end else begin
              mctl.wmark = oaht_pkg::MarkOccupied;
              mctl.wkv   = 1'b1;
              occ_d      = occ_q + CntW'(1);
              if (have_tomb_q && tmb_q != '0) tmb_d = tmb_q - CntW'(1);
            end
          end
          oaht_pkg::OpRemove: begin
            if (hit_q) begin
              mctl.we    = 1'b1;
              mctl.waddr = idx_q;
              mctl.wmark = oaht_pkg::MarkDeleted;
              tmb_d      = tmb_q + CntW'(1);
              if (occ_q != '0) occ_d = occ_q - CntW'(1);
            end
          end
          default: ;
        endcase
      end
      oaht_pkg::StIterRd: state_d = oaht_pkg::StIterChk;
      oaht_pkg::StIterChk: begin
        if (rmark == oaht_pkg::MarkOccupied) begin
          found_d = 1'b1;
          rkey_d  = rkey;
          rval_d  = rval;
          sidx_d  = 11'(idx_q);
          state_d = oaht_pkg::StDone;
        end else if (idx_q == IdxW'(oaht_pkg::Capacity - 1)) begin
          state_d = oaht_pkg::StDone;
        end else begin
          idx_d   = idx_q + IdxW'(1);
          state_d = oaht_pkg::StIterRd;
        end
      end
      oaht_pkg::StDone: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = oaht_pkg::StIdle;
      end
      default: state_d = oaht_pkg::StIdle;
    endcase
  end

  assign found_o        = found_q;
  assign status_o       = status_q;
  assign result_value_o = rval_q;
  assign result_key_o   = rkey_q;
  assign slot_index_o   = sidx_q;
  assign entry_count_o  = 11'(occ_q);

endmodule

>>> tb/hash_table_checker.sv
`timescale 1ns / 1ps

module hash_table_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [2:0]  opcode_i,
  input  logic [31:0] key_i,
  input  logic [31:0] hash_value_i,
  input  logic [31:0] value_i,
  input  logic [31:0] default_value_i,
  input  logic [10:0] start_index_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        found_i,
  input  logic        status_i,
  input  logic [31:0] result_value_i,
  input  logic [31:0] result_key_i,
  input  logic [10:0] slot_index_i,
  input  logic [10:0] entry_count_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);

  typedef struct packed {
    logic        found;
    logic        status;
    logic [31:0] rval;
    logic [31:0] rkey;
    logic [10:0] sidx;
    logic [10:0] cnt;
  } answer_t;

  oaht_pkg::mark_e marks [oaht_pkg::Capacity];
  logic [31:0]     keys  [oaht_pkg::Capacity];
  logic [31:0]     vals  [oaht_pkg::Capacity];
  int unsigned     occ, tombs;
  answer_t         answers [$];

  function automatic int unsigned walk_probe(logic [31:0] k, logic [31:0] h, output bit hit);
    int unsigned i, stp, tomb;
    bit have;
    i = h & (oaht_pkg::Capacity - 1);
    stp = 1;
    have = 0;
    tomb = 0;
    hit = 0;
    for (int n = 0; n < oaht_pkg::Capacity; n++) begin
      if (marks[i] == oaht_pkg::MarkEmpty) return have ? tomb : i;
      if (marks[i] == oaht_pkg::MarkDeleted) begin
        if (!have) begin
          have = 1;
          tomb = i;
        end
      end else if (keys[i] == k) begin
        hit = 1;
        return i;
      end
      if (n + 1 < oaht_pkg::Capacity) begin
        i = (i + stp) & (oaht_pkg::Capacity - 1);
        stp++;
      end
    end
    return have ? tomb : i;
  endfunction

  function automatic answer_t apply_request(logic [2:0] op, logic [31:0] k, logic [31:0] h,
                                            logic [31:0] v, logic [31:0] dv, logic [10:0] st);
    answer_t a;
    bit hit;
    int unsigned s;
    a = '0;
    case (op)
      oaht_pkg::OpLookup: begin
        s = walk_probe(k, h, hit);
        a.found = hit;
        a.rval = hit ? vals[s] : dv;
        a.sidx = 11'(s);
      end
      oaht_pkg::OpAdd: begin
        if ((occ + tombs + 1) * 3 >= oaht_pkg::Capacity * 2) begin
          a.status = 1;
        end else begin
          s = walk_probe(k, h, hit);
          a.sidx = 11'(s);
          vals[s] = v;
          if (hit) begin
            a.found = 1;
          end else begin
            if (marks[s] == oaht_pkg::MarkDeleted && tombs > 0) tombs--;
            keys[s] = k;
            marks[s] = oaht_pkg::MarkOccupied;
            occ++;
          end
        end
      end
      oaht_pkg::OpRemove: begin
        s = walk_probe(k, h, hit);
        a.sidx = 11'(s);
        if (hit) begin
          a.found = 1;
          marks[s] = oaht_pkg::MarkDeleted;
          tombs++;
          if (occ > 0) occ--;
        end
      end
      oaht_pkg::OpClear: begin
        foreach (marks[j]) marks[j] = oaht_pkg::MarkEmpty;
        occ = 0;
        tombs = 0;
      end
      oaht_pkg::OpIterate: begin
        a.sidx = 11'(oaht_pkg::Capacity);
        if (occ != 0) begin
          for (int j = st; j < oaht_pkg::Capacity; j++) begin
            if (marks[j] == oaht_pkg::MarkOccupied) begin
              a.found = 1;
              a.rkey = keys[j];
              a.rval = vals[j];
              a.sidx = 11'(j);
              break;
            end
          end
        end
      end
      default: ;
    endcase
    a.cnt = 11'(occ);
    return a;
  endfunction

  initial begin
    foreach (marks[j]) marks[j] = oaht_pkg::MarkEmpty;
    occ = 0;
    tombs = 0;
    fail_count_o = 0;
    checked_o = 0;
  end

  assign pending_o = answers.size();

  always @(posedge clk_i) begin
    answer_t e, got;
    if (rst_ni && in_valid_i && in_ready_i)
      answers.push_back(apply_request(opcode_i, key_i, hash_value_i, value_i,
                                      default_value_i, start_index_i));
    if (rst_ni && out_valid_i && out_ready_i) begin
      got = '{found_i, status_i, result_value_i, result_key_i, slot_index_i, entry_count_i};
      checked_o <= checked_o + 1;
      if (answers.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        fail_count_o <= fail_count_o + 1;
      end else begin
        e = answers.pop_front();
        if (e.found !== got.found || e.status !== got.status || e.rval !== got.rval ||
            e.rkey !== got.rkey || e.sidx !== got.sidx || e.cnt !== got.cnt) begin
          $display("%0t: mismatch exp found=%b st=%b val=%h key=%h slot=%0d cnt=%0d",
                   $time, e.found, e.status, e.rval, e.rkey, e.sidx, e.cnt);
          $display("%0t:          act found=%b st=%b val=%h key=%h slot=%0d cnt=%0d",
                   $time, got.found, got.status, got.rval, got.rkey, got.sidx, got.cnt);
          fail_count_o <= fail_count_o + 1;
        end
      end
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_ready_o;
  logic [2:0]  opcode_i = 0;
  logic [31:0] key_i = 0, hash_value_i = 0, value_i = 0, default_value_i = 0;
  logic [10:0] start_index_i = 0;
  logic        out_valid_o;
  logic        out_ready_i = 0;
  logic        found_o, status_o;
  logic [31:0] result_value_o, result_key_o;
  logic [10:0] slot_index_o, entry_count_o;
  int          fail_count, pending, checked;
  int          cycles = 0;
  logic [31:0] key_pool [16];
  logic [31:0] hash_pool [16];

  localparam int Limit = 3_000_000;

  always #6 clk_i = ~clk_i;

  open_address_hash_table u_top (.*);

  hash_table_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .opcode_i, .key_i,
    .hash_value_i, .value_i, .default_value_i, .start_index_i,
    .out_valid_i(out_valid_o), .out_ready_i, .found_i(found_o), .status_i(status_o),
    .result_value_i(result_value_o), .result_key_i(result_key_o),
    .slot_index_i(slot_index_o), .entry_count_i(entry_count_o),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int g;
    forever begin
      @(posedge clk_i);
      g = gap_len();
      out_ready_i <= (g == 0) || ($urandom_range(0, 3) == 0);
    end
  end

  task automatic send(logic [2:0] op, logic [31:0] k, logic [31:0] h, logic [31:0] v,
                      logic [31:0] dv, logic [10:0] st, bit no_gap);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    key_i <= k;
    hash_value_i <= h;
    value_i <= v;
    default_value_i <= dv;
    start_index_i <= st;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
  endtask

  task automatic send_random(bit no_gap);
    int p, r;
    logic [31:0] k, h;
    p = $urandom_range(0, 15);
    r = $urandom_range(0, 99);
    if (r < 85) begin
      k = key_pool[p];
      h = hash_pool[p];
    end else begin
      k = $urandom;
      h = $urandom;
    end
    if (r < 30) send(oaht_pkg::OpAdd, k, h, $urandom, $urandom, 0, no_gap);
    else if (r < 55) send(oaht_pkg::OpLookup, k, h, $urandom, $urandom, 0, no_gap);
    else if (r < 78) send(oaht_pkg::OpRemove, k, h, $urandom, $urandom, 0, no_gap);
    else if (r < 92) send(oaht_pkg::OpIterate, k, h, 0, 0, $urandom_range(0, 1100), no_gap);
    else if (r < 93) send(oaht_pkg::OpClear, k, h, 0, 0, 0, no_gap);
    else send(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom, $urandom,
              11'($urandom), no_gap);
  endtask

  initial begin
    foreach (key_pool[i]) begin
      key_pool[i] = $urandom;
      hash_pool[i] = (i < 8) ? 32'h5 : $urandom;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    send(oaht_pkg::OpIterate, 0, 0, 0, 0, 0, 0);
    send(oaht_pkg::OpLookup, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 32'hDEAD_BEEF, 0, 0);
    send(oaht_pkg::OpAdd, 0, 0, 32'hFFFF_FFFF, 0, 0, 0);
    send(oaht_pkg::OpAdd, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0);
    send(oaht_pkg::OpAdd, 32'h1, 0, 32'h1234, 0, 0, 0);
    send(oaht_pkg::OpAdd, 32'h2, 0, 32'h5678, 0, 0, 0);
    send(oaht_pkg::OpAdd, 32'h1, 0, 32'hAAAA_5555, 0, 0, 0);
    send(oaht_pkg::OpLookup, 32'h2, 0, 0, 32'h1, 0, 0);
    send(oaht_pkg::OpRemove, 32'h1, 0, 0, 0, 0, 0);
    send(oaht_pkg::OpRemove, 32'h1, 0, 0, 0, 0, 0);
    send(oaht_pkg::OpLookup, 32'h1, 0, 0, 32'h5555_AAAA, 0, 0);
    send(oaht_pkg::OpAdd, 32'h3, 0, 32'h3, 0, 0, 0);
    send(oaht_pkg::OpIterate, 0, 0, 0, 0, 0, 0);
    send(oaht_pkg::OpIterate, 0, 0, 0, 0, 11'd1023, 0);
    send(oaht_pkg::OpIterate, 0, 0, 0, 0, 11'd1024, 0);
    send(oaht_pkg::OpIterate, 0, 0, 0, 0, 11'h7FF, 0);
    send(3'd5, 32'h1, 0, 0, 0, 0, 0);
    send(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'h7FF, 0);
    send(oaht_pkg::OpClear, 0, 0, 0, 0, 0, 0);
    send(oaht_pkg::OpLookup, 32'h2, 0, 0, 32'h7, 0, 0);

    // pile keys onto one home slot back to back to force long probes
    for (int i = 0; i < 60; i++) send(oaht_pkg::OpAdd, $urandom, 32'h40, $urandom, 0, 0, 1);
    send(oaht_pkg::OpAdd, 32'h2, 32'h40, 32'h9, 0, 0, 0);
    for (int i = 0; i < 20; i++) send_random(0);
    drain();
    send(oaht_pkg::OpClear, 0, 0, 0, 0, 0, 0);

    for (int i = 0; i < 300; i++) begin
      if (i == 150) drain();
      send_random(0);
    end

    drain();
    repeat (50) @(posedge clk_i);
    $display("Ran directed corner cases, a burst of colliding adds and random mixes of");
    $display("lookup/add/remove/iterate/clear; %0d results checked.", checked);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
